/* hdl/four_channel_sample_mixer_macros.svh */
// assertion macros for the four-channel sample mixer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef FOUR_CHANNEL_SAMPLE_MIXER_MACROS_SVH
`define FOUR_CHANNEL_SAMPLE_MIXER_MACROS_SVH

// same-cycle implication, off during reset
`define FCSM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcsm check failed");

// next-cycle implication, off during reset
`define FCSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcsm check failed");

`endif

/* hdl/fcsm_pkg.sv */
// shared constants, payload types, control structs and helpers for the mixer
// no dependencies; the controller, datapath, top level and checker import this package
package fcsm_pkg;

    // sample memory depth must be a power of two (addresses wrap)
    localparam int SAMPLE_WORDS = 65536;
    localparam int NUM_EFFECTS  = 64;
    localparam int NUM_CHANNELS = 4;

    localparam int SAMPLE_AW = $clog2(SAMPLE_WORDS);
    localparam int EFFECT_AW = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;
    localparam int CHAN_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ACC_W     = 16 + CHAN_W;
    localparam int SUM_W     = (SAMPLE_AW > 18) ? SAMPLE_AW : 18;
    localparam int EIDX_W    = (EFFECT_AW > 6) ? EFFECT_AW : 6;
    localparam int LEN_W     = 17;
    localparam int EFFECT_DW = 16 + LEN_W;

    localparam logic [LEN_W-1:0]        MAX_LEN = 17'h10000;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);

    typedef enum logic [1:0] {
        OP_WRITE_SAMPLE = 2'd0,
        OP_WRITE_EFFECT = 2'd1,
        OP_PLAY         = 2'd2,
        OP_TICK         = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
        logic [5:0]         effect_index;
        logic [16:0]        effect_length;
        logic [1:0]         channel;
        logic               pick_free;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               play_started;
        logic [1:0]         play_channel;
        logic [3:0]         active_mask;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLAY_APPLY,
        ST_CH_LOOK,
        ST_CH_CHECK,
        ST_CH_ACC,
        ST_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic sample_wr;
        logic effect_wr;
        logic play_rd;
        logic play_apply;
        logic chan_rd;
        logic chan_expire;
        logic sample_rd;
        logic chan_acc;
        logic chan_next;
        logic finish;
    } dp_ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic chan_active;
        logic pos_ge_len;
        logic last_chan;
    } dp_stat_t;

    function automatic logic [SAMPLE_AW-1:0] sample_addr(input logic [15:0] base,
                                                         input logic [LEN_W-1:0] offs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(offs);
        return s[SAMPLE_AW-1:0];
    endfunction

    function automatic logic [EFFECT_AW-1:0] effect_addr(input logic [5:0] idx);
        logic [EIDX_W-1:0] w;
        w = EIDX_W'(idx);
        return w[EFFECT_AW-1:0];
    endfunction

    function automatic logic effect_ok(input logic [5:0] idx);
        return 32'(idx) < 32'(NUM_EFFECTS);
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // divide by 4, truncating toward zero
    function automatic logic signed [13:0] quarter(input logic signed [15:0] s);
        logic signed [15:0] b;
        b = s + (s[15] ? 16'sd3 : 16'sd0);
        return 14'(b >>> 2);
    endfunction

endpackage

/* hdl/fcsm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module fcsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* hdl/fcsm_ctrl.sv */
// controller state machine of the mixer: sequences loads, plays and channel visits
// depends on fcsm_pkg
module fcsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fcsm_pkg::dp_stat_t stat,
    output fcsm_pkg::dp_ctrl_t ctrl
);
    import fcsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.op) inside
                    OP_WRITE_SAMPLE, OP_WRITE_EFFECT: state_next = ST_FINISH;
                    OP_PLAY:                          state_next = ST_PLAY_APPLY;
                    OP_TICK:                          state_next = ST_CH_LOOK;
                    default:                          state_next = ST_FINISH;
                endcase
            end
            ST_PLAY_APPLY:
            begin
                state_next = ST_FINISH;
            end
            ST_CH_LOOK:
            begin
                if (stat.chan_active)
                begin
                    state_next = ST_CH_CHECK;
                end
                else if (stat.last_chan)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CH_CHECK:
            begin
                if (!stat.pos_ge_len)
                begin
                    state_next = ST_CH_ACC;
                end
                else if (stat.last_chan)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CH_LOOK;
                end
            end
            ST_CH_ACC:
            begin
                state_next = stat.last_chan ? ST_FINISH : ST_CH_LOOK;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                ctrl.latch = start;
            end
            ST_DECODE:
            begin
                ctrl.sample_wr = (stat.op == OP_WRITE_SAMPLE);
                ctrl.effect_wr = (stat.op == OP_WRITE_EFFECT);
                ctrl.play_rd   = (stat.op == OP_PLAY);
            end
            ST_PLAY_APPLY:
            begin
                ctrl.play_apply = 1'b1;
            end
            ST_CH_LOOK:
            begin
                ctrl.chan_rd   = stat.chan_active;
                ctrl.chan_next = !stat.chan_active;
            end
            ST_CH_CHECK:
            begin
                ctrl.chan_expire = stat.pos_ge_len;
                ctrl.chan_next   = stat.pos_ge_len;
                ctrl.sample_rd   = !stat.pos_ge_len;
            end
            ST_CH_ACC:
            begin
                ctrl.chan_acc  = 1'b1;
                ctrl.chan_next = 1'b1;
            end
            ST_FINISH:
            begin
                ctrl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/fcsm_datapath.sv */
// mixer datapath: sample and effect memories, channel registers, accumulator, result
// depends on fcsm_pkg and fcsm_ram
module fcsm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fcsm_pkg::cmd_t     cmd,
    input  fcsm_pkg::dp_ctrl_t ctrl,
    output fcsm_pkg::dp_stat_t stat,
    output logic               done,
    output fcsm_pkg::result_t  result
);
    import fcsm_pkg::*;

    cmd_t                     cmd_reg;
    logic [CHAN_W-1:0]        chan_idx_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_sat;
    logic                     started_reg;
    logic [1:0]               started_ch_reg;
    logic [NUM_CHANNELS-1:0]  chan_active_reg;
    logic [EFFECT_AW-1:0]     chan_effect_reg [NUM_CHANNELS];
    logic [LEN_W-1:0]         chan_pos_reg [NUM_CHANNELS];
    logic [NUM_EFFECTS-1:0]   eff_valid_reg;
    logic                     eff_rd_valid_reg;
    logic                     done_reg;
    result_t                  result_reg;

    logic                     eff_we;
    logic                     eff_re;
    logic [EFFECT_AW-1:0]     eff_raddr;
    logic [EFFECT_DW-1:0]     eff_rdata;
    logic [15:0]              eff_start;
    logic [LEN_W-1:0]         eff_len;
    logic [15:0]              smp_rdata;

    logic [LEN_W-1:0]         pos_cur;
    logic [LEN_W-1:0]         pos_inc;
    logic                     free_found;
    logic [CHAN_W-1:0]        free_idx;
    logic [CHAN_W-1:0]        named_idx;
    logic                     play_go;
    logic                     play_clear;
    logic [CHAN_W-1:0]        play_tgt;

    // effect table: start address in the upper bits, length in the lower
    assign eff_we    = ctrl.effect_wr && effect_ok(cmd_reg.effect_index);
    assign eff_re    = ctrl.play_rd || ctrl.chan_rd;
    assign eff_raddr = ctrl.play_rd ? effect_addr(cmd_reg.effect_index)
                                    : chan_effect_reg[chan_idx_reg];

    fcsm_ram #(
        .WIDTH (EFFECT_DW),
        .DEPTH (NUM_EFFECTS)
    ) u_effect_ram (
        .clk   (clk),
        .we    (eff_we),
        .waddr (effect_addr(cmd_reg.effect_index)),
        .wdata ({cmd_reg.address, sat_len(cmd_reg.effect_length)}),
        .re    (eff_re),
        .raddr (eff_raddr),
        .rdata (eff_rdata)
    );

    assign eff_start = eff_rdata[EFFECT_DW-1:LEN_W];
    // entries never written read as zero length
    assign eff_len   = eff_rd_valid_reg ? eff_rdata[LEN_W-1:0] : '0;

    assign pos_cur = chan_pos_reg[chan_idx_reg];
    assign pos_inc = pos_cur + 17'd1;

    fcsm_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ctrl.sample_wr),
        .waddr (sample_addr(cmd_reg.address, '0)),
        .wdata (cmd_reg.sample_value),
        .re    (ctrl.sample_rd),
        .raddr (sample_addr(eff_start, pos_cur)),
        .rdata (smp_rdata)
    );

    // lowest-numbered free channel
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (!chan_active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = CHAN_W'(i);
            end
        end
    end

    assign named_idx = CHAN_W'(cmd_reg.channel);

    always_comb
    begin
        play_go    = 1'b0;
        play_clear = 1'b0;
        play_tgt   = '0;
        if (effect_ok(cmd_reg.effect_index))
        begin
            if (cmd_reg.pick_free)
            begin
                if (free_found && eff_len != '0)
                begin
                    play_go  = 1'b1;
                    play_tgt = free_idx;
                end
            end
            else if (32'(cmd_reg.channel) < 32'(NUM_CHANNELS))
            begin
                if (eff_len == '0)
                begin
                    play_clear = 1'b1;
                end
                else
                begin
                    play_go  = 1'b1;
                    play_tgt = named_idx;
                end
            end
        end
    end

    always_comb
    begin
        if (sum_reg > ACC_MAX)
        begin
            sum_sat = ACC_MAX;
        end
        else if (sum_reg < ACC_MIN)
        begin
            sum_sat = ACC_MIN;
        end
        else
        begin
            sum_sat = sum_reg;
        end
    end

    assign stat.op          = cmd_reg.op;
    assign stat.chan_active = chan_active_reg[chan_idx_reg];
    assign stat.pos_ge_len  = (pos_cur >= eff_len);
    assign stat.last_chan   = (chan_idx_reg == CHAN_W'(NUM_CHANNELS - 1));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_active_reg <= '0;
            eff_valid_reg   <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (eff_we)
            begin
                eff_valid_reg[effect_addr(cmd_reg.effect_index)] <= 1'b1;
            end
            if (ctrl.play_apply && play_clear)
            begin
                chan_active_reg[named_idx] <= 1'b0;
            end
            if (ctrl.play_apply && play_go)
            begin
                chan_active_reg[play_tgt] <= 1'b1;
            end
            if (ctrl.chan_expire)
            begin
                chan_active_reg[chan_idx_reg] <= 1'b0;
            end
            if (ctrl.chan_acc && pos_inc >= eff_len)
            begin
                chan_active_reg[chan_idx_reg] <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg        <= cmd;
            chan_idx_reg   <= '0;
            sum_reg        <= '0;
            started_reg    <= 1'b0;
            started_ch_reg <= '0;
        end
        if (eff_re)
        begin
            eff_rd_valid_reg <= eff_valid_reg[eff_raddr];
        end
        if (ctrl.play_apply && play_go)
        begin
            chan_effect_reg[play_tgt] <= effect_addr(cmd_reg.effect_index);
            chan_pos_reg[play_tgt]    <= '0;
            started_reg               <= 1'b1;
            started_ch_reg            <= 2'(play_tgt);
        end
        if (ctrl.chan_acc)
        begin
            chan_pos_reg[chan_idx_reg] <= pos_inc;
            sum_reg <= sum_reg + ACC_W'(quarter($signed(smp_rdata)));
        end
        if (ctrl.chan_next)
        begin
            chan_idx_reg <= stat.last_chan ? '0 : chan_idx_reg + CHAN_W'(1);
        end
        if (ctrl.finish)
        begin
            result_reg.left_sample  <= 16'(sum_sat);
            result_reg.right_sample <= 16'(sum_sat);
            result_reg.play_started <= started_reg;
            result_reg.play_channel <= started_ch_reg;
            result_reg.active_mask  <= 4'(chan_active_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/four_channel_sample_mixer.sv */
// top level of the four-channel sample mixer
// depends on fcsm_pkg, fcsm_ctrl and fcsm_datapath
//
// Four-channel sound-effect player. An item is taken when start is high and
// busy is low; its single result appears on result for exactly one cycle with
// done high, and must be captured then, since the receiver cannot hold it off.
// Sample and effect writes pass decode and finish, a play decode, apply and
// finish. A tick visits the channels one after another through the single read
// port of the effect table and of the sample memory: an idle channel is only
// looked at, a run-out one looked at and checked, a playing one also summed.
// busy falls in the cycle that shows done, so the next item may be taken there.
// No clearing pass is needed after reset; unwritten effects play as empty.
module four_channel_sample_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fcsm_pkg::cmd_t    cmd,
    output logic              done,
    output fcsm_pkg::result_t result
);
    import fcsm_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    fcsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    fcsm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctrl   (ctrl),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

/* hdl/fcsm_checker.sv */
// port-level checks for the mixer, bound onto the top level
// depends on fcsm_pkg and four_channel_sample_mixer_macros.svh
`include "four_channel_sample_mixer_macros.svh"

module fcsm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input fcsm_pkg::cmd_t    cmd,
    input logic              done,
    input fcsm_pkg::result_t result
);
    import fcsm_pkg::*;

    logic cmd_seen;

    assign cmd_seen = (cmd.op == OP_TICK) || (cmd.op != OP_TICK);

    // a taken transfer keeps the block busy on the next cycle
    `FCSM_ASSERT_NEXT(a_accept_busy, start && !busy && cmd_seen, busy)
    // a result only follows work in progress
    `FCSM_ASSERT_IMPLIES(a_done_after_busy, done, $past(busy))
    `FCSM_ASSERT_IMPLIES(a_stereo_equal, done, result.left_sample == result.right_sample)
    // no play started means channel reads zero
    `FCSM_ASSERT_IMPLIES(a_channel_zero, done && !result.play_started, result.play_channel == 2'd0)

endmodule

bind four_channel_sample_mixer fcsm_checker u_fcsm_checker (.*);
